// ----- rtl/core/scancode_to_ascii_decoder_unit_assert.svh -----
// Assertion macros for the scan-code decoder.
`ifndef SCANCODE_TO_ASCII_DECODER_UNIT_ASSERT_SVH
`define SCANCODE_TO_ASCII_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SCD_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define SCD_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define SCD_ASSERT_IMPL(label, clk, rst, prop)
`define SCD_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- rtl/core/scd_pkg.sv -----
package scd_pkg;

   localparam int unsigned KEYCODE_TABLE_DEPTH = 128;

   typedef logic [3:0] kind_type;
   localparam kind_type KIND_LATIN   = 4'd0;
   localparam kind_type KIND_SPECIAL = 4'd2;
   localparam kind_type KIND_KEYPAD  = 4'd3;
   localparam kind_type KIND_MOD     = 4'd7;
   localparam kind_type KIND_LETTER  = 4'd11;

   localparam logic [15:0] ENTRY_HOLE = 16'hf200;
   localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
   localparam logic [7:0]  CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0]  CHAR_DELETE = 8'h7f;
   localparam logic [7:0]  ALT_BIT = 8'h80;
   localparam logic [7:0]  CASE_OFFSET = 8'h20;
   localparam logic [7:0]  SPECIAL_ENTER = 8'd1;
   localparam logic [7:0]  SPECIAL_CAPS = 8'd7;
   localparam logic [7:0]  KEYPAD_ENTER = 8'd14;

   typedef struct packed {
      logic shift_held;
      logic ctrl_held;
      logic alt_held;
      logic caps_lock_on;
      logic awaiting_enter_release;
   } flags_type;

   function automatic logic [15:0] map_plain(input logic [6:0] k);
      logic [15:0] t [KEYCODE_TABLE_DEPTH];
      t = '{
         16'hf200,16'hf01b,16'hf031,16'hf032,16'hf033,16'hf034,16'hf035,16'hf036,
         16'hf037,16'hf038,16'hf039,16'hf030,16'hf02d,16'hf03d,16'hf07f,16'hf009,
         16'hfb71,16'hfb77,16'hfb65,16'hfb72,16'hfb74,16'hfb79,16'hfb75,16'hfb69,
         16'hfb6f,16'hfb70,16'hf05b,16'hf05d,16'hf201,16'hf702,16'hfb61,16'hfb73,
         16'hfb64,16'hfb66,16'hfb67,16'hfb68,16'hfb6a,16'hfb6b,16'hfb6c,16'hf03b,
         16'hf027,16'hf060,16'hf700,16'hf05c,16'hfb7a,16'hfb78,16'hfb63,16'hfb76,
         16'hfb62,16'hfb6e,16'hfb6d,16'hf02c,16'hf02e,16'hf02f,16'hf700,16'hf30c,
         16'hf703,16'hf020,16'hf207,16'hf100,16'hf101,16'hf102,16'hf103,16'hf104,
         16'hf105,16'hf106,16'hf107,16'hf108,16'hf109,16'hf208,16'hf209,16'hf307,
         16'hf308,16'hf309,16'hf30b,16'hf304,16'hf305,16'hf306,16'hf30a,16'hf301,
         16'hf302,16'hf303,16'hf300,16'hf310,16'hf206,16'hf200,16'hf03c,16'hf10a,
         16'hf10b,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,
         16'hf30e,16'hf702,16'hf30d,16'hf01c,16'hf701,16'hf205,16'hf114,16'hf603,
         16'hf118,16'hf601,16'hf602,16'hf117,16'hf600,16'hf119,16'hf115,16'hf116,
         16'hf11a,16'hf10c,16'hf10d,16'hf11b,16'hf11c,16'hf110,16'hf311,16'hf11d,
         16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200};
      return t[k];
   endfunction

   function automatic logic [15:0] map_shift(input logic [6:0] k);
      logic [15:0] t [KEYCODE_TABLE_DEPTH];
      t = '{
         16'hf200,16'hf01b,16'hf021,16'hf040,16'hf023,16'hf024,16'hf025,16'hf05e,
         16'hf026,16'hf02a,16'hf028,16'hf029,16'hf05f,16'hf02b,16'hf07f,16'hf009,
         16'hfb51,16'hfb57,16'hfb45,16'hfb52,16'hfb54,16'hfb59,16'hfb55,16'hfb49,
         16'hfb4f,16'hfb50,16'hf07b,16'hf07d,16'hf201,16'hf702,16'hfb41,16'hfb53,
         16'hfb44,16'hfb46,16'hfb47,16'hfb48,16'hfb4a,16'hfb4b,16'hfb4c,16'hf03a,
         16'hf022,16'hf07e,16'hf700,16'hf07c,16'hfb5a,16'hfb58,16'hfb43,16'hfb56,
         16'hfb42,16'hfb4e,16'hfb4d,16'hf03c,16'hf03e,16'hf03f,16'hf700,16'hf30c,
         16'hf703,16'hf020,16'hf207,16'hf10a,16'hf10b,16'hf10c,16'hf10d,16'hf10e,
         16'hf10f,16'hf110,16'hf111,16'hf112,16'hf113,16'hf213,16'hf203,16'hf307,
         16'hf308,16'hf309,16'hf30b,16'hf304,16'hf305,16'hf306,16'hf30a,16'hf301,
         16'hf302,16'hf303,16'hf300,16'hf310,16'hf206,16'hf200,16'hf03e,16'hf10a,
         16'hf10b,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,
         16'hf30e,16'hf702,16'hf30d,16'hf200,16'hf701,16'hf205,16'hf114,16'hf603,
         16'hf20b,16'hf601,16'hf602,16'hf117,16'hf600,16'hf20a,16'hf115,16'hf116,
         16'hf11a,16'hf10c,16'hf10d,16'hf11b,16'hf11c,16'hf110,16'hf311,16'hf11d,
         16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200};
      return t[k];
   endfunction

   function automatic logic [15:0] map_ctrl(input logic [6:0] k);
      logic [15:0] t [KEYCODE_TABLE_DEPTH];
      t = '{
         16'hf200,16'hf200,16'hf200,16'hf000,16'hf01b,16'hf01c,16'hf01d,16'hf01e,
         16'hf01f,16'hf07f,16'hf200,16'hf200,16'hf01f,16'hf200,16'hf008,16'hf200,
         16'hf011,16'hf017,16'hf005,16'hf012,16'hf014,16'hf019,16'hf015,16'hf009,
         16'hf00f,16'hf010,16'hf01b,16'hf01d,16'hf201,16'hf702,16'hf001,16'hf013,
         16'hf004,16'hf006,16'hf007,16'hf008,16'hf00a,16'hf00b,16'hf00c,16'hf200,
         16'hf007,16'hf000,16'hf700,16'hf01c,16'hf01a,16'hf018,16'hf003,16'hf016,
         16'hf002,16'hf00e,16'hf00d,16'hf200,16'hf20e,16'hf07f,16'hf700,16'hf30c,
         16'hf703,16'hf000,16'hf207,16'hf100,16'hf101,16'hf102,16'hf103,16'hf104,
         16'hf105,16'hf106,16'hf107,16'hf108,16'hf109,16'hf208,16'hf204,16'hf307,
         16'hf308,16'hf309,16'hf30b,16'hf304,16'hf305,16'hf306,16'hf30a,16'hf301,
         16'hf302,16'hf303,16'hf300,16'hf310,16'hf206,16'hf200,16'hf200,16'hf10a,
         16'hf10b,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,
         16'hf30e,16'hf702,16'hf30d,16'hf01c,16'hf701,16'hf205,16'hf114,16'hf603,
         16'hf118,16'hf601,16'hf602,16'hf117,16'hf600,16'hf119,16'hf115,16'hf116,
         16'hf11a,16'hf10c,16'hf10d,16'hf11b,16'hf11c,16'hf110,16'hf311,16'hf11d,
         16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200,16'hf200};
      return t[k];
   endfunction

endpackage

// ----- rtl/core/scd_decode.sv -----
// Combinational decode of one scan byte against the current key flags.
module scd_decode (
   input  logic [7:0]         scan_byte,
   input  scd_pkg::flags_type flags,
   output scd_pkg::flags_type flags_next,
   output logic               emit,
   output logic [7:0]         char_code
);
   logic                released;
   logic [6:0]          key;
   logic [15:0]         entry;
   scd_pkg::kind_type   kind;
   logic [7:0]          v;
   logic [7:0]          latin_v;

   assign released = scan_byte[7];
   assign key      = scan_byte[6:0];

   always_comb begin
      priority if (flags.shift_held) begin
         entry = scd_pkg::map_shift(key);
      end else if (flags.ctrl_held) begin
         entry = scd_pkg::map_ctrl(key);
      end else begin
         entry = scd_pkg::map_plain(key);
      end
   end

   assign kind    = entry[11:8];
   assign v       = entry[7:0];
   assign latin_v = flags.alt_held ? (v | scd_pkg::ALT_BIT) : v;

   always_comb begin
      flags_next = flags;
      emit       = 1'b0;
      char_code  = v;
      if (flags.awaiting_enter_release) begin
         if (released) begin
            flags_next.awaiting_enter_release = 1'b0;
            emit      = 1'b1;
            char_code = scd_pkg::CHAR_NEWLINE;
         end
      end else if (kind == scd_pkg::KIND_MOD) begin
         if (v == 8'd0 || v == 8'd4 || v == 8'd5) begin
            flags_next.shift_held = ~released;
         end else if (v == 8'd1 || v == 8'd3) begin
            flags_next.alt_held = ~released;
         end else if (v == 8'd2 || v == 8'd6 || v == 8'd7) begin
            flags_next.ctrl_held = ~released;
         end
      end else if (!released) begin
         unique case (kind)
            scd_pkg::KIND_LATIN: begin
               emit      = 1'b1;
               char_code = (latin_v == scd_pkg::CHAR_DELETE) ? scd_pkg::CHAR_BACKSPACE
                                                             : latin_v;
            end
            scd_pkg::KIND_LETTER: begin
               emit = 1'b1;
               if (flags.caps_lock_on && v >= 8'h61 && v <= 8'h7a) begin
                  char_code = v - scd_pkg::CASE_OFFSET;
               end
            end
            scd_pkg::KIND_SPECIAL: begin
               if (v == scd_pkg::SPECIAL_CAPS) begin
                  flags_next.caps_lock_on = ~flags.caps_lock_on;
               end else if (v == scd_pkg::SPECIAL_ENTER) begin
                  flags_next.awaiting_enter_release = 1'b1;
               end
            end
            scd_pkg::KIND_KEYPAD: begin
               if (v < 8'd10) begin
                  emit      = 1'b1;
                  char_code = 8'h30 + v;
               end else if (v == scd_pkg::KEYPAD_ENTER) begin
                  flags_next.awaiting_enter_release = 1'b1;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end
endmodule

// ----- rtl/core/scancode_to_ascii_decoder_unit.sv -----
// Scan-code set 1 to character decoder.
// Input channel req_: one raw scan byte per word (bit 7 = key release,
// bits 6..0 = keycode). Result channel rsp_: one character per word;
// newline is 10, backspace is 8. A byte yields at most one character:
// modifier, caps-lock and most release bytes yield none.
// A character appears on rsp_ in the cycle after its byte is taken.
// Throughput: one byte per cycle while no held result is stalled on rsp_;
// the single decode pass (map lookup plus flag update) sits between the
// byte handshake and the result register. The keycode is 7 bits wide and
// the maps are 128 entries deep, so every keycode has an entry.
// Enter and keypad enter produce their newline on the next release byte.
// Reset clears the shift, ctrl, alt, caps-lock and enter-wait flags and
// empties the result register.
// Stall: while the result register holds a word that is not taken, hold
// the word and drop req_ready, whatever the next byte would produce; a
// new byte is taken in the same cycle as the held word leaves.
`include "scancode_to_ascii_decoder_unit_assert.svh"
module scancode_to_ascii_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_char_code
);
   scd_pkg::flags_type flags_ff, flags_in, dec_flags;
   logic               dec_emit;
   logic [7:0]         dec_char;
   logic               valid_ff, valid_in;
   logic [7:0]         char_ff, char_in;
   logic               take;

   scd_decode u_decode (
      .scan_byte  (req_scan_byte),
      .flags      (flags_ff),
      .flags_next (dec_flags),
      .emit       (dec_emit),
      .char_code  (dec_char)
   );

   // Free slot when empty or draining this cycle.
   assign req_ready = !valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      flags_in = flags_ff;
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      if (take) begin
         flags_in = dec_flags;
         if (dec_emit) begin
            valid_in = 1'b1;
            char_in  = dec_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         flags_ff <= flags_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;

   `SCD_ASSERT_IMPL(a_hold_when_stalled, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid)
   `SCD_ASSERT_IMPL(a_newline_after_wait, clock, reset, (take && flags_ff.awaiting_enter_release && req_scan_byte[7]) |=> (rsp_valid && rsp_char_code == scd_pkg::CHAR_NEWLINE && !flags_ff.awaiting_enter_release))
   `SCD_ASSERT_IMPL(a_no_ready_when_full, clock, reset, (valid_ff && !rsp_ready) |-> !req_ready)
   `SCD_ASSERT_NORST(a_reset_clears, clock, reset |=> (!rsp_valid && flags_ff == '0))
endmodule

// ----- dv/scancode_to_ascii_decoder_unit_tb.sv -----
module scancode_to_ascii_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Scoreboard: keeps its own copy of the decoder flags and the characters
   // still owed by the block.
   class char_scoreboard;
      scd_pkg::flags_type flags;
      logic [7:0]         owed_chars[$];
      int                 errors;

      function void clear();
         flags = '0;
         owed_chars.delete();
         errors = 0;
      endfunction

      function logic [15:0] lookup_entry(logic [6:0] k);
         if (flags.shift_held) return scd_pkg::map_shift(k);
         if (flags.ctrl_held) return scd_pkg::map_ctrl(k);
         return scd_pkg::map_plain(k);
      endfunction

      // Note an accepted scan byte and queue the character it should give.
      function void note_byte(logic [7:0] b);
         logic               rel;
         logic [15:0]        e;
         scd_pkg::kind_type  kind;
         logic [7:0]         v;
         rel = b[7];
         if (flags.awaiting_enter_release) begin
            if (rel) begin
               flags.awaiting_enter_release = 1'b0;
               owed_chars.push_back(scd_pkg::CHAR_NEWLINE);
            end
            return;
         end
         e = lookup_entry(b[6:0]);
         kind = e[11:8];
         v = e[7:0];
         if (kind == scd_pkg::KIND_MOD) begin
            if (v == 0 || v == 4 || v == 5) flags.shift_held = !rel;
            else if (v == 1 || v == 3) flags.alt_held = !rel;
            else if (v == 2 || v == 6 || v == 7) flags.ctrl_held = !rel;
            return;
         end
         if (rel) return;
         case (kind)
            scd_pkg::KIND_LATIN: begin
               if (flags.alt_held) v = v | scd_pkg::ALT_BIT;
               if (v == scd_pkg::CHAR_DELETE) v = scd_pkg::CHAR_BACKSPACE;
               owed_chars.push_back(v);
            end
            scd_pkg::KIND_LETTER: begin
               if (flags.caps_lock_on && v >= "a" && v <= "z") v = v - scd_pkg::CASE_OFFSET;
               owed_chars.push_back(v);
            end
            scd_pkg::KIND_SPECIAL: begin
               if (v == scd_pkg::SPECIAL_CAPS) flags.caps_lock_on = !flags.caps_lock_on;
               else if (v == scd_pkg::SPECIAL_ENTER) flags.awaiting_enter_release = 1'b1;
            end
            scd_pkg::KIND_KEYPAD: begin
               if (v < 10) owed_chars.push_back(8'h30 + v);
               else if (v == scd_pkg::KEYPAD_ENTER) flags.awaiting_enter_release = 1'b1;
            end
            default: ;
         endcase
      endfunction

      function void check_char(logic [7:0] got);
         logic [7:0] want;
         if (owed_chars.size() == 0) begin
            $error("char_code: no character expected, got %0d", got);
            errors++;
            return;
         end
         want = owed_chars.pop_front();
         if (got !== want) begin
            $error("char_code: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_scan_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_char_code;

   char_scoreboard sb;
   int unsigned    cycle_count;
   bit             stall_on;

   localparam int unsigned CYCLE_LIMIT = 200000;

   scancode_to_ascii_decoder_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_scan_byte(req_scan_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_char_code(rsp_char_code)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Sample both handshakes at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_scan_byte);
         if (rsp_valid && rsp_ready) sb.check_char(rsp_char_code);
      end
   end

   // Receiver stall pattern: runs of ready and of stall, plus stall-free stretches.
   initial begin
      int run;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         run = $urandom_range(1, 12);
         if (stall_on) rsp_ready <= ($urandom_range(0, 2) != 0);
         else rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         if ($urandom_range(0, 9) == 0) stall_on = !stall_on;
         if (stall_on) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
      end
   end

   // Present one word and hold it until taken; leave valid high for the next.
   task automatic send_byte(input logic [7:0] b);
      req_valid     <= 1'b1;
      req_scan_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Send a byte inside a burst, with occasional gaps.
   int burst_left;
   task automatic push_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      end
      burst_left--;
      send_byte(b);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed_chars.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Pick a keycode with a bias towards printable keys.
   function automatic logic [6:0] pick_key();
      case ($urandom_range(0, 5))
         0, 1: return 7'($urandom_range(16, 50));
         2: return 7'($urandom_range(2, 13));
         3: return 7'($urandom_range(71, 83));
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   initial begin
      logic [6:0] k;
      sb = new();
      sb.clear();
      cycle_count = 0;
      stall_on = 1'b1;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_scan_byte = 8'h00;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, every kind, caps, alt, ctrl, shift, enter waits, holes.
      send_byte(8'h00);  send_byte(8'hff);  send_byte(8'h7f);
      send_byte(8'h1e);  send_byte(8'h3a);  send_byte(8'h1e);  send_byte(8'h3a);
      send_byte(8'h2a);  send_byte(8'h1e);  send_byte(8'haa);
      send_byte(8'h38);  send_byte(8'h0e);  send_byte(8'h00);  send_byte(8'hb8);
      send_byte(8'h1d);  send_byte(8'h10);  send_byte(8'h9d);
      send_byte(8'h47);  send_byte(8'h52);  send_byte(8'h53);
      send_byte(8'h1c);  send_byte(8'h1e);  send_byte(8'h9c);
      send_byte(8'h60);  send_byte(8'he0);

      // Hold off until every owed character is out.
      drain();

      for (int i = 0; i < 1625; i++) begin
         k = pick_key();
         case ($urandom_range(0, 9))
            0: push_byte({1'b0, 7'(($urandom_range(0, 1)) ? 7'h2a : 7'h36)});
            1: push_byte({1'b1, 7'(($urandom_range(0, 1)) ? 7'h2a : 7'h1d)});
            2: push_byte({$urandom_range(0, 1) == 1, 7'h38});
            3: push_byte({$urandom_range(0, 1) == 1, 7'h1d});
            4: push_byte(8'($urandom_range(0, 255)));
            default: push_byte({$urandom_range(0, 5) == 0, k});
         endcase
         if (i == 800) drain();
      end

      drain();
      repeat (10) @(negedge clock);
      if (sb.owed_chars.size() != 0) begin
         $error("char_code: %0d characters never arrived", sb.owed_chars.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ----- scancode_to_ascii_decoder_unit.f -----
+incdir+rtl/core
rtl/core/scd_pkg.sv
rtl/core/scd_decode.sv
rtl/core/scancode_to_ascii_decoder_unit.sv
dv/scancode_to_ascii_decoder_unit_tb.sv
